[rtl/sktab_pkg.sv]
`default_nettype none
package sktab_pkg;

    // Default sizes handed to the top level.
    localparam int DEFAULT_DEPTH     = 16;
    localparam int DEFAULT_TAG_WIDTH = 16;

    // Fixed field widths of the channels.
    localparam int ACT_W    = 2;
    localparam int TAG_IO_W = 16;
    localparam int KEY_W    = 32;
    localparam int ORG_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int STAT_W   = 2;
    localparam int CNT_IO_W = 5;
    localparam int LIMIT_W  = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Per-cell controls; do_insert and do_remove are shared by every cell.
    typedef struct packed {
        logic occupied;   // the cell holds a live entry
        logic at_count;   // the cell is the first free slot
        logic do_insert;  // an insert transaction is committed this cycle
        logic do_remove;  // a remove transaction is committed this cycle
    } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/sorted_key_table_unit.sv]
`default_nettype none
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_stall    | action, value_tag, sort_key, origin_index,
//          |                        | read_slot
// output   | out_valid / out_stall  | status, entry_count, read_value, read_key,
//          |                        | read_origin
// config   | cfg_wr_en              | cfg_wr_data (table_limit)
//
// Every transaction is completed by a row of DEPTH cells that compare and shift in
// parallel; the result appears in the output register on the next cycle.
// A new transaction is taken in any cycle in which the output register is empty or
// being emptied, so the sustained rate is one transaction per cycle while out_stall
// is low. The remove search ripples combinationally through the row of cells.
// Reset clears the entry count, the output valid flag and sets table_limit to 16.
// While out_stall holds a result, in_stall is raised and the table does not change.
module sorted_key_table_unit
    import sktab_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int TAG_WIDTH = DEFAULT_TAG_WIDTH
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire  [LIMIT_W-1:0]          cfg_wr_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire  [ACT_W-1:0]            action,
    input  wire  [TAG_IO_W-1:0]         value_tag,
    input  wire  signed [KEY_W-1:0]     sort_key,
    input  wire  [ORG_W-1:0]            origin_index,
    input  wire  [SLOT_W-1:0]           read_slot,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [STAT_W-1:0]           status,
    output logic [CNT_IO_W-1:0]         entry_count,
    output logic [TAG_IO_W-1:0]         read_value,
    output logic signed [KEY_W-1:0]     read_key,
    output logic [ORG_W-1:0]            read_origin
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [TAG_IO_W-1:0] rval_reg, rval_next;
    logic [KEY_W-1:0]    rkey_reg, rkey_next;
    logic [ORG_W-1:0]    rorg_reg, rorg_next;

    logic                accept;
    logic                is_insert, is_remove, is_read;
    logic                full, found, slot_ok;
    logic [TAG_WIDTH-1:0] tag_in;
    int                  limit_eff;

    logic                 mark [DEPTH];
    logic                 seen [DEPTH];
    logic [TAG_WIDTH-1:0] c_tag [DEPTH];
    logic [KEY_W-1:0]     c_key [DEPTH];
    logic [ORG_W-1:0]     c_org [DEPTH];
    cell_ctl_t            ctl [DEPTH];

    // Handshake: a held result blocks new transactions.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tag_in   = TAG_WIDTH'(value_tag);

    // Decode the transaction and its conditions.
    always_comb
    begin
        is_insert = (action == ACT_INSERT);
        is_remove = (action == ACT_REMOVE);
        is_read   = (action == ACT_READ);
        limit_eff = (32'(limit_reg) > DEPTH) ? DEPTH : 32'(limit_reg);
        full      = (32'(count_reg) >= limit_eff);
        found     = seen[DEPTH-1];
        slot_ok   = (32'(read_slot) < 32'(count_reg));
    end

    // The row of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            ctl[i].occupied  = (i < 32'(count_reg));
            ctl[i].at_count  = (i == 32'(count_reg));
            ctl[i].do_insert = accept && is_insert && !full;
            ctl[i].do_remove = accept && is_remove;
        end

        sktab_cell #(
            .TAG_WIDTH (TAG_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .new_tag   (tag_in),
            .new_key   (sort_key),
            .new_org   (origin_index),
            .prev_mark ((i == 0) ? 1'b0 : mark[(i == 0) ? 0 : i - 1]),
            .prev_seen ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]),
            .lo_tag    (c_tag[(i == 0) ? 0 : i - 1]),
            .lo_key    (c_key[(i == 0) ? 0 : i - 1]),
            .lo_org    (c_org[(i == 0) ? 0 : i - 1]),
            .hi_tag    (c_tag[(i == DEPTH - 1) ? i : i + 1]),
            .hi_key    (c_key[(i == DEPTH - 1) ? i : i + 1]),
            .hi_org    (c_org[(i == DEPTH - 1) ? i : i + 1]),
            .mark      (mark[i]),
            .seen      (seen[i]),
            .tag       (c_tag[i]),
            .key       (c_key[i]),
            .org       (c_org[i])
        );
    end

    // Next count, status and read data.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        rval_next   = '0;
        rkey_next   = '0;
        rorg_next   = '0;
        case (action_t'(action))
            ACT_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            ACT_REMOVE:
            begin
                if (found)
                    count_next = count_reg - 1'b1;
                else
                    status_next = ST_NOT_FOUND;
            end
            ACT_READ:
            begin
                if (slot_ok)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (32'(read_slot) == i)
                        begin
                            rval_next = TAG_IO_W'(c_tag[i]);
                            rkey_next = c_key[i];
                            rorg_next = c_org[i];
                        end
                    end
                end
                else
                    status_next = ST_EMPTY;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register, loaded with each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rval_reg   <= rval_next;
            rkey_reg   <= rkey_next;
            rorg_reg   <= rorg_next;
        end
    end

    logic [CW-1:0] count_out_reg;

    // The count reported is the one after the transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
            count_out_reg <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = CNT_IO_W'(count_out_reg);
    assign read_value  = rval_reg;
    assign read_key    = rkey_reg;
    assign read_origin = rorg_reg;

`ifndef SYNTHESIS
    // The table never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count exceeds depth");

    // An insert that is not refused grows the table by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_insert && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table");

    // A read never alters the entry count.
    a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_read |=> count_reg == $past(count_reg))
        else $error("read changed the entry count");

    // A successful remove result reports one entry fewer.
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_remove && found |=>
        (status_reg == ST_OK) && (count_reg == $past(count_reg) - 1'b1))
        else $error("remove result inconsistent with count");
`endif

endmodule
`default_nettype wire

[rtl/sktab_cell.sv]
`default_nettype none
module sktab_cell
    import sktab_pkg::*;
#(
    parameter int TAG_WIDTH = DEFAULT_TAG_WIDTH
)
(
    input  wire                         clk,
    input  wire  cell_ctl_t             ctl,
    // New entry broadcast to all cells.
    input  wire  [TAG_WIDTH-1:0]        new_tag,
    input  wire  signed [KEY_W-1:0]     new_key,
    input  wire  [ORG_W-1:0]            new_org,
    // Neighbour below (slot i-1).
    input  wire                         prev_mark,
    input  wire                         prev_seen,
    input  wire  [TAG_WIDTH-1:0]        lo_tag,
    input  wire  signed [KEY_W-1:0]     lo_key,
    input  wire  [ORG_W-1:0]            lo_org,
    // Neighbour above (slot i+1).
    input  wire  [TAG_WIDTH-1:0]        hi_tag,
    input  wire  signed [KEY_W-1:0]     hi_key,
    input  wire  [ORG_W-1:0]            hi_org,
    // Own contents and chain outputs.
    output logic                        mark,
    output logic                        seen,
    output logic [TAG_WIDTH-1:0]        tag,
    output logic signed [KEY_W-1:0]     key,
    output logic [ORG_W-1:0]            org
);

    logic [TAG_WIDTH-1:0]    tag_reg, tag_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ORG_W-1:0]        org_reg, org_next;
    logic                    not_smaller;
    logic                    hit;

    // Local compares: the insert point is the first slot whose key is not smaller.
    always_comb
    begin
        not_smaller = ctl.occupied && (new_key <= key_reg);
        mark        = not_smaller || ctl.at_count;
        hit         = ctl.occupied && (tag_reg == new_tag);
        seen        = prev_seen || hit;
    end

    // Shift up on insert, shift down from the first match on remove.
    always_comb
    begin
        tag_next = tag_reg;
        key_next = key_reg;
        org_next = org_reg;
        if (ctl.do_insert)
        begin
            if (prev_mark)
            begin
                tag_next = lo_tag;
                key_next = lo_key;
                org_next = lo_org;
            end
            else if (mark)
            begin
                tag_next = new_tag;
                key_next = new_key;
                org_next = new_org;
            end
        end
        else if (ctl.do_remove && seen)
        begin
            tag_next = hi_tag;
            key_next = hi_key;
            org_next = hi_org;
        end
    end

    // Entry storage; contents are only read once written.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        key_reg <= key_next;
        org_reg <= org_next;
    end

    assign tag = tag_reg;
    assign key = key_reg;
    assign org = org_reg;

endmodule
`default_nettype wire
